FILE: sv/edbm_pkg.sv
// Shared types, constants and helpers for the nearest-word edit distance search.
package edbm_pkg;

  // Word length bound (words of MAX_WORD characters or more saturate) and largest dictionary counted
  localparam int MAX_WORD = 32;
  localparam int MAX_DICT = 4096;

  // Derived widths
  localparam int IDX_W   = $clog2(MAX_WORD);       // column / store index
  localparam int LEN_W   = $clog2(MAX_WORD + 1);   // lengths up to MAX_WORD
  localparam int DIST_W  = $clog2(2 * MAX_WORD + 1);
  localparam int CNT_W   = $clog2(MAX_DICT + 1);   // word count up to MAX_DICT
  localparam int INDEX_W = 12;                     // match_index field
  localparam int CHAR_W  = 8;
  localparam int CMD_W   = 2;
  localparam int THR_W   = 7;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(2);

  // Input word commands
  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY     = 2'd0,
    CMD_WORD_CHAR = 2'd1,
    CMD_CLOSE     = 2'd2,
    CMD_FINISH    = 2'd3
  } command_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_query;
    logic start_char;
    logic step;
    logic close_word;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_loop;
    logic last;
    logic out_full;
  } dp_status_t;

  // Smallest of three distances
  function automatic logic [DIST_W-1:0] min3(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b,
                                             input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

FILE: sv/edbm_ifs.sv
// Handshake channel interfaces: input words, result words and threshold writes.
interface edbm_in_if;
  import edbm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_code;
  modport source (output valid, output command, output char_code, input ready);
  modport sink   (input valid, input command, input char_code, output ready);
endinterface

interface edbm_out_if;
  import edbm_pkg::*;
  logic               valid;
  logic               ready;
  logic               match_found;
  logic [INDEX_W-1:0] match_index;
  modport source (output valid, output match_found, output match_index, input ready);
  modport sink   (input valid, input match_found, input match_index, output ready);
endinterface

interface edbm_cfg_if;
  import edbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] match_threshold;
  modport source (output valid, output match_threshold, input ready);
  modport sink   (input valid, input match_threshold, output ready);
endinterface

FILE: sv/edbm_ctrl.sv
// Sequencing state machine: accepts words and steps the column update.
module edbm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [edbm_pkg::CMD_W-1:0] in_command,
  output logic                  in_ready,
  input  edbm_pkg::dp_status_t  status,
  output edbm_pkg::ctrl_cmd_t   cmd
);
  import edbm_pkg::*;

  state_t   state_r, state_nxt;
  command_t in_cmd;
  logic     accept;

  assign in_cmd = command_t'(in_command);

  // A finish word waits while the result register is still occupied
  assign in_ready = (state_r == ST_IDLE) && ((in_cmd != CMD_FINISH) || !status.out_full);
  assign accept   = in_valid && in_ready;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd == CMD_WORD_CHAR) && status.need_loop) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (status.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load_query = accept && (in_cmd == CMD_QUERY);
        cmd.start_char = accept && (in_cmd == CMD_WORD_CHAR);
        cmd.close_word = accept && (in_cmd == CMD_CLOSE);
        cmd.finish     = accept && (in_cmd == CMD_FINISH);
      end
      ST_UPDATE: begin
        cmd.step = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: sv/edbm_datapath.sv
// Query store, distance column, best-match tracking and result register.
module edbm_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  edbm_pkg::ctrl_cmd_t          cmd,
  output edbm_pkg::dp_status_t         status,
  input  logic [edbm_pkg::CHAR_W-1:0]  in_char,
  input  logic                         cfg_valid,
  input  logic [edbm_pkg::THR_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic [edbm_pkg::INDEX_W-1:0] out_index
);
  import edbm_pkg::*;

  logic [CHAR_W-1:0]  qstore_r [MAX_WORD];
  logic [LEN_W-1:0]   qlen_r;
  logic [DIST_W-1:0]  col_r [MAX_WORD];
  logic [MAX_WORD-1:0] colv_r;
  logic [LEN_W-1:0]   pos_r;
  logic               too_long_r;
  logic [DIST_W-1:0]  best_r;
  logic [INDEX_W-1:0] bidx_r;
  logic [CNT_W-1:0]   wcnt_r;
  logic [IDX_W-1:0]   idx_r;
  logic [DIST_W-1:0]  diag_r, left_r;
  logic [CHAR_W-1:0]  ch_r;
  logic [THR_W-1:0]   thr_r;
  logic               out_valid_r, out_found_r;
  logic [INDEX_W-1:0] out_index_r;

  logic [IDX_W-1:0]   rd_addr;
  logic [DIST_W-1:0]  rd_val, col0_val, new_val, word_dist;
  logic [CHAR_W-1:0]  q_char;
  logic [LEN_W-1:0]   pos_next;
  logic               query_full, char_go, dict_open;

  // Shared column read port: close reads the query-length entry, steps read idx
  assign rd_addr  = cmd.close_word ? qlen_r[IDX_W-1:0] : idx_r;
  assign rd_val   = colv_r[rd_addr] ? col_r[rd_addr] : DIST_W'(rd_addr);
  assign col0_val = colv_r[0] ? col_r[0] : '0;
  assign q_char   = qstore_r[IDX_W'(idx_r - 1'b1)];

  // Cell update: match takes the diagonal, else one more than the smallest neighbour
  assign new_val = (q_char == ch_r) ? diag_r
                                    : DIST_W'(min3(rd_val, left_r, diag_r) + 1'b1);

  assign query_full = (qlen_r >= LEN_W'(MAX_WORD));
  assign pos_next   = LEN_W'(pos_r + 1'b1);
  assign char_go    = !too_long_r && !query_full;
  assign dict_open  = (wcnt_r < CNT_W'(MAX_DICT));
  assign word_dist  = (too_long_r || query_full) ? DIST_W'(2 * MAX_WORD) : rd_val;

  // Status to the controller
  assign status.need_loop = char_go && (pos_next < LEN_W'(MAX_WORD)) && (qlen_r != '0);
  assign status.last      = ({1'b0, idx_r} == qlen_r);
  assign status.out_full  = out_valid_r && !out_ready;

  // Query store, written in load order
  always_ff @(posedge clk) begin
    if (cmd.load_query && !query_full) begin
      qstore_r[qlen_r[IDX_W-1:0]] <= in_char;
    end
  end

  // Distance column payload
  always_ff @(posedge clk) begin
    if (cmd.start_char && char_go && (pos_next < LEN_W'(MAX_WORD))) begin
      col_r[0] <= DIST_W'(pos_next);
    end else if (cmd.step) begin
      col_r[idx_r] <= new_val;
    end
  end

  // Step pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.start_char) begin
      diag_r <= col0_val;
      left_r <= DIST_W'(pos_next);
      idx_r  <= IDX_W'(1);
      ch_r   <= in_char;
    end else if (cmd.step) begin
      diag_r <= rd_val;
      left_r <= new_val;
      idx_r  <= IDX_W'(idx_r + 1'b1);
    end
  end

  // Search control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r     <= '0;
      colv_r     <= '0;
      pos_r      <= '0;
      too_long_r <= 1'b0;
      best_r     <= DIST_W'(2 * MAX_WORD);
      bidx_r     <= '0;
      wcnt_r     <= '0;
    end else begin
      if (cmd.load_query) begin
        if (!query_full) begin
          qlen_r <= LEN_W'(qlen_r + 1'b1);
        end
        colv_r     <= '0;
        pos_r      <= '0;
        too_long_r <= 1'b0;
      end
      if (cmd.start_char && char_go) begin
        if (pos_next < LEN_W'(MAX_WORD)) begin
          pos_r     <= pos_next;
          colv_r[0] <= 1'b1;
        end else begin
          too_long_r <= 1'b1;
          pos_r      <= LEN_W'(MAX_WORD);
        end
      end
      if (cmd.step) begin
        colv_r[idx_r] <= 1'b1;
      end
      if (cmd.close_word) begin
        if (dict_open) begin
          if (word_dist < best_r) begin
            best_r <= word_dist;
            bidx_r <= wcnt_r[INDEX_W-1:0];
          end
          wcnt_r <= CNT_W'(wcnt_r + 1'b1);
        end
        colv_r     <= '0;
        pos_r      <= '0;
        too_long_r <= 1'b0;
      end
      if (cmd.finish) begin
        qlen_r     <= '0;
        colv_r     <= '0;
        pos_r      <= '0;
        too_long_r <= 1'b0;
        best_r     <= DIST_W'(2 * MAX_WORD);
        bidx_r     <= '0;
        wcnt_r     <= '0;
      end
    end
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found_r <= (wcnt_r != '0) && ({1'b0, best_r} <= {1'b0, thr_r});
      out_index_r <= ((wcnt_r != '0) && ({1'b0, best_r} <= {1'b0, thr_r})) ? bidx_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_index = out_index_r;

`ifndef SYNTH
  // Column steps stay within the stored query
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (idx_r != '0) && ({1'b0, idx_r} <= qlen_r))
    else $error("column step index outside query");

  // Best distance only falls between finishes
  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.finish |=> best_r <= $past(best_r))
    else $error("best distance increased");

  // Finish leaves a cleared search
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (wcnt_r == '0) && (qlen_r == '0) && (best_r == DIST_W'(2 * MAX_WORD)))
    else $error("search not cleared after finish");

  // Top of the column tracks the word position while the word is in range
  a_col0_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !too_long_r |-> col0_val == DIST_W'(pos_r))
    else $error("column head out of step with word position");
`endif

endmodule

FILE: sv/edit_distance_best_match.sv
// Nearest dictionary word search by edit distance. Load the query with query-character
// words, then stream each dictionary word as character words followed by a close word;
// a finish word returns one result (found flag and index of the first closest word) and
// clears the search, keeping the threshold. For a dictionary character the distance
// column is updated one query position per cycle through a single shared cell-update
// unit, and no input word is taken until the update is done. No update is needed
// when the query is empty or has reached MAX_WORD characters, or when the word reaches
// MAX_WORD characters. A finish word is held off while a previous result is still
// waiting to be taken.
module edit_distance_best_match (
  input  logic        clk,
  input  logic        rst_n,
  edbm_in_if.sink     in_bus,
  edbm_out_if.source  out_bus,
  edbm_cfg_if.sink    cfg_bus
);
  import edbm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_bus.ready = 1'b1;

  // Sequencer
  edbm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_command (in_bus.command),
    .in_ready   (in_bus.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Storage and arithmetic
  edbm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_char   (in_bus.char_code),
    .cfg_valid (cfg_bus.valid),
    .cfg_data  (cfg_bus.match_threshold),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_found (out_bus.match_found),
    .out_index (out_bus.match_index)
  );

endmodule

FILE: tb/tb_edit_distance_best_match.sv
// Self-checking testbench for the nearest-word edit distance search block.
module tb_edit_distance_best_match;
  timeunit 1ns;
  timeprecision 1ps;

  import edbm_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 50;   // longer than one dictionary character takes
  localparam int RANDOM_WORDS = 1300;
  localparam int GAP_PCT = 13;

  typedef struct packed {
    command_t          cmd;
    logic [CHAR_W-1:0] ch;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
  } match_result_t;

  logic clk;
  logic rst_n;

  edbm_in_if  in_ch();
  edbm_out_if out_ch();
  edbm_cfg_if cfg_ch();

  edit_distance_best_match u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  in_word_t      pending_words[$];
  match_result_t expected_matches[$];
  int words_queued;
  int words_accepted;
  int random_words;
  int searches_reported;
  int threshold_writes;
  int mismatches;
  int cycle_count;
  bit steady;   // no gaps on either side while set

  // Predicted search state
  logic [CHAR_W-1:0]  q_chars[MAX_WORD];
  logic [LEN_W-1:0]   q_len;
  logic [DIST_W-1:0]  dist_col[MAX_WORD];
  logic [LEN_W-1:0]   w_pos;
  logic               w_long;
  logic [DIST_W-1:0]  best_dist;
  logic [INDEX_W-1:0] best_idx;
  logic [CNT_W-1:0]   dict_count;
  logic [THR_W-1:0]   threshold_model;

  function automatic void restart_word();
    for (int i = 0; i < MAX_WORD; i++) dist_col[i] = DIST_W'(i);
    w_pos = '0;
    w_long = 1'b0;
  endfunction

  function automatic void clear_search();
    restart_word();
    q_len = '0;
    best_dist = DIST_W'(2 * MAX_WORD);
    best_idx = '0;
    dict_count = '0;
  endfunction

  // One dictionary character advances the distance column
  function automatic void dict_char(input logic [CHAR_W-1:0] ch);
    logic [DIST_W-1:0] diag;
    logic [DIST_W-1:0] old;
    logic [DIST_W-1:0] low;
    if (w_long || q_len >= MAX_WORD) return;
    if (int'(w_pos) + 1 >= MAX_WORD) begin
      w_long = 1'b1;
      w_pos = LEN_W'(MAX_WORD);
      return;
    end
    w_pos = w_pos + 1'b1;
    diag = dist_col[0];
    dist_col[0] = DIST_W'(w_pos);
    for (int i = 1; i <= int'(q_len) && i < MAX_WORD; i++) begin
      old = dist_col[i];
      if (q_chars[i-1] == ch) begin
        dist_col[i] = diag;
      end else begin
        low = (old < dist_col[i-1]) ? old : dist_col[i-1];
        if (diag < low) low = diag;
        dist_col[i] = low + 1'b1;
      end
      diag = old;
    end
  endfunction

  // Work out the effect of one accepted input word
  function automatic void advance_search(input command_t cmd, input logic [CHAR_W-1:0] ch);
    logic [DIST_W-1:0] close_dist;
    match_result_t     res;
    case (cmd)
      CMD_QUERY: begin
        if (q_len < MAX_WORD) begin
          q_chars[q_len[IDX_W-1:0]] = ch;
          q_len = q_len + 1'b1;
        end
        restart_word();
      end
      CMD_WORD_CHAR: begin
        dict_char(ch);
      end
      CMD_CLOSE: begin
        if (dict_count < MAX_DICT) begin
          if (w_long || q_len >= MAX_WORD) close_dist = DIST_W'(2 * MAX_WORD);
          else close_dist = dist_col[q_len[IDX_W-1:0]];
          // strict compare: the first closest word wins
          if (close_dist < best_dist) begin
            best_dist = close_dist;
            best_idx = INDEX_W'(dict_count);
          end
          dict_count = dict_count + 1'b1;
        end
        restart_word();
      end
      default: begin
        res.found = (dict_count > 0) && (best_dist <= threshold_model);
        res.index = res.found ? best_idx : '0;
        expected_matches.push_back(res);
        clear_search();
      end
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  // Input driver: pops pending words, random gaps
  always @(posedge clk) begin : drive_words
    in_word_t next_word;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.command   <= CMD_QUERY;
      in_ch.char_code <= '0;
      clear_search();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_search(command_t'(in_ch.command), in_ch.char_code);
        words_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() > 0 && (steady || $urandom_range(99) >= GAP_PCT)) begin
          next_word = pending_words.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.command   <= next_word.cmd;
          in_ch.char_code <= next_word.ch;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure, compare with oldest prediction
  always @(posedge clk) begin : watch_results
    match_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        searches_reported++;
        if (expected_matches.size() == 0) begin
          note_mismatch("unexpected result, match_index", -1, int'(out_ch.match_index));
        end else begin
          want = expected_matches.pop_front();
          if (out_ch.match_found !== want.found)
            note_mismatch("match_found", int'(want.found), int'(out_ch.match_found));
          if (out_ch.match_index !== want.index)
            note_mismatch("match_index", int'(want.index), int'(out_ch.match_index));
        end
      end
      out_ch.ready <= steady || ($urandom_range(99) >= GAP_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic queue_word(input command_t cmd, input logic [CHAR_W-1:0] ch);
    pending_words.push_back('{cmd: cmd, ch: ch});
    words_queued++;
  endtask

  // Mostly a small alphabet so that words come close to the query
  function automatic logic [CHAR_W-1:0] pick_char(input bit wide);
    if (wide) return CHAR_W'($urandom_range(255));
    return CHAR_W'(8'h61 + $urandom_range(3));
  endfunction

  // Wait for every word to go in and every result to come out
  task automatic drain();
    while (words_accepted != words_queued || expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.match_threshold <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    threshold_model = value;
    cfg_ch.valid <= 1'b0;
    threshold_writes++;
  endtask

  // One search: query, a few dictionary words (mostly edits of the query), finish
  task automatic queue_random_search();
    logic [CHAR_W-1:0] qtext[$];
    logic [CHAR_W-1:0] wtext[$];
    logic [CHAR_W-1:0] ch;
    int  qlen, nwords, r, wlen, pos;
    bit  wide;
    wide = ($urandom_range(99) < 20);
    r = $urandom_range(99);
    if (r < 80) qlen = $urandom_range(8);
    else if (r < 94) qlen = $urandom_range(20, 9);
    else qlen = $urandom_range(34, 30);
    for (int k = 0; k < qlen; k++) begin
      ch = pick_char(wide);
      qtext.push_back(ch);
      queue_word(CMD_QUERY, ch);
    end
    nwords = ($urandom_range(99) < 8) ? 0 : $urandom_range(6, 1);
    for (int w = 0; w < nwords; w++) begin
      wtext.delete();
      r = $urandom_range(99);
      if (r < 60) begin
        // query with up to three random edits
        wtext = qtext;
        repeat ($urandom_range(3)) begin
          pos = (wtext.size() == 0) ? 0 : $urandom_range(wtext.size() - 1);
          case ($urandom_range(2))
            0: wtext.insert(pos, pick_char(wide));
            1: if (wtext.size() > 0) wtext.delete(pos);
            default: if (wtext.size() > 0) wtext[pos] = pick_char(wide);
          endcase
        end
      end else begin
        wlen = (r < 90) ? $urandom_range(10) : $urandom_range(34, 29);
        repeat (wlen) wtext.push_back(pick_char(wide));
      end
      foreach (wtext[k]) begin
        queue_word(CMD_WORD_CHAR, wtext[k]);
        // rare query character in the middle of a word
        if ($urandom_range(199) == 0) begin
          ch = pick_char(wide);
          qtext.push_back(ch);
          queue_word(CMD_QUERY, ch);
        end
      end
      // occasionally leave the word open
      if ($urandom_range(99) < 94) queue_word(CMD_CLOSE, CHAR_W'($urandom));
    end
    queue_word(CMD_FINISH, CHAR_W'($urandom));
  endtask

  task automatic queue_random_searches(input int count);
    int start;
    start = words_queued;
    while (words_queued - start < count) queue_random_search();
    random_words += words_queued - start;
  endtask

  initial begin : stimulus
    logic [THR_W-1:0] thr;
    rst_n = 1'b0;
    steady = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.match_threshold = '0;
    threshold_model = THR_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed searches at the reset threshold
    // equal later distance keeps the first closest word
    queue_word(CMD_QUERY, "a");
    queue_word(CMD_QUERY, "b");
    queue_word(CMD_WORD_CHAR, "b");
    queue_word(CMD_CLOSE, 8'h00);
    queue_word(CMD_WORD_CHAR, "a");
    queue_word(CMD_WORD_CHAR, "b");
    queue_word(CMD_CLOSE, 8'hFF);
    queue_word(CMD_WORD_CHAR, "a");
    queue_word(CMD_WORD_CHAR, "b");
    queue_word(CMD_CLOSE, 8'h5A);
    queue_word(CMD_FINISH, 8'h00);
    // empty dictionary
    queue_word(CMD_FINISH, 8'hFF);
    // extreme characters, query char during a word, word left open at finish
    queue_word(CMD_QUERY, 8'h00);
    queue_word(CMD_QUERY, 8'hFF);
    queue_word(CMD_WORD_CHAR, 8'hFF);
    queue_word(CMD_WORD_CHAR, 8'h00);
    queue_word(CMD_CLOSE, 8'h00);
    queue_word(CMD_WORD_CHAR, 8'hFF);
    queue_word(CMD_QUERY, 8'h55);
    queue_word(CMD_CLOSE, 8'hAA);
    queue_word(CMD_WORD_CHAR, 8'h00);
    queue_word(CMD_FINISH, 8'h00);
    drain();

    // A threshold of 2 * MAX_WORD admits the saturated distance
    write_threshold(THR_W'(2 * MAX_WORD));
    // query too long
    repeat (MAX_WORD + 1) queue_word(CMD_QUERY, "x");
    queue_word(CMD_WORD_CHAR, "x");
    queue_word(CMD_WORD_CHAR, "y");
    queue_word(CMD_CLOSE, 8'h00);
    queue_word(CMD_FINISH, 8'h00);
    // word too long
    queue_word(CMD_QUERY, "a");
    queue_word(CMD_QUERY, "b");
    queue_word(CMD_QUERY, "c");
    repeat (MAX_WORD) queue_word(CMD_WORD_CHAR, "a");
    queue_word(CMD_CLOSE, 8'h00);
    queue_word(CMD_FINISH, 8'h00);
    queue_random_searches(250);
    drain();

    // Zero threshold, no gaps on either side
    steady = 1'b1;
    write_threshold('0);
    queue_random_searches(250);
    drain();
    steady = 1'b0;

    // Remaining random phases over further thresholds
    for (int phase = 0; random_words < RANDOM_WORDS; phase++) begin
      case (phase)
        0: thr = THR_W'(1);
        1: thr = THR_W'(63);
        2: thr = THR_W'(3);
        default: thr = THR_W'($urandom_range(2 * MAX_WORD));
      endcase
      write_threshold(thr);
      queue_random_searches(250);
      drain();
    end

    $display("Ran %0d input words (%0d random) over %0d threshold settings",
             words_accepted, random_words, threshold_writes + 1);
    $display("Checked %0d search results in %0d cycles", searches_reported, cycle_count);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
